/* src/mbpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mbpc_pkg;

    // Field widths fixed by the item format
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned IDX_W   = 7;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 2;

    // Default number of pattern cells
    localparam int unsigned MAX_PATTERN_DEF = 128;

    // Saturation level of the match counter
    localparam logic [COUNT_W-1:0] COUNT_SAT = 2'd2;

    // Item operation codes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_SCAN = 1'b1
    } op_t;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic scan;   // accepted scan request
        logic last;   // scan request carries the final text byte
        logic load;   // accepted load request
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* src/masked_byte_pattern_counter_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// A result is registered from the accepted scan request that carries the final byte.
// Throughput: one request per cycle while not stalled; on a scan every pattern cell
// updates and the cell hits are ORed into the saturating counter in the same cycle.
// Input stalls only while a result is held and the output side stalls.
// Reset: partial matches, counter, pattern length and result valid clear;
// pattern entries are undefined until loaded.

module masked_byte_pattern_counter_core
    import mbpc_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic               operation,
    input  wire logic [IDX_W-1:0]   entry_index,
    input  wire logic [BYTE_W-1:0]  data_byte,
    input  wire logic               must_match,
    input  wire logic               last_byte,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [COUNT_W-1:0]      match_count,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LEN_W-1:0]   cfg_data
);

    logic [LEN_W-1:0]       length_reg;
    logic [COUNT_W-1:0]     found_reg;
    logic [COUNT_W-1:0]     found_next;
    logic [COUNT_W-1:0]     count_sum;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [COUNT_W-1:0]     out_count_reg;
    logic                   accept;
    logic                   any_hit;
    cell_ctrl_t             ctrl;
    logic [MAX_PATTERN-1:0] match_vec;
    logic [MAX_PATTERN-1:0] hit_vec;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            length_reg <= cfg_data;
        end
    end

    // Hold input only while a result waits on a stalled output
    assign item_stall = out_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        ctrl.scan = accept && (operation == OP_SCAN);
        ctrl.last = accept && (operation == OP_SCAN) && last_byte;
        ctrl.load = accept && (operation == OP_LOAD);
    end

    // Row of pattern cells, each handing its partial match to the next
    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        logic prev;

        if (j == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_link
            assign prev = match_vec[j-1];
        end

        mbpc_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .CELL_INDEX  (j)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .entry_index    (entry_index),
            .data_byte      (data_byte),
            .must_match     (must_match),
            .pattern_length (length_reg),
            .prev_match     (prev),
            .match          (match_vec[j]),
            .hit            (hit_vec[j])
        );
    end

    // Advance the saturating counter on a completed match, clear it on the final byte
    assign any_hit   = |hit_vec;
    assign count_sum = (any_hit && (found_reg != COUNT_SAT)) ? found_reg + 2'd1 : found_reg;

    always_comb
    begin
        found_next = found_reg;
        if (ctrl.scan)
        begin
            found_next = ctrl.last ? '0 : count_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.last)
        begin
            out_count_reg <= count_sum;
        end
    end

    assign result_valid = out_valid_reg;
    assign match_count  = out_count_reg;

endmodule

`default_nettype wire

/* src/mbpc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbpc_cell
    import mbpc_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int unsigned CELL_INDEX  = 0
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [IDX_W-1:0]  entry_index,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              must_match,
    input  wire logic [LEN_W-1:0]  pattern_length,
    input  wire logic              prev_match,
    output logic                   match,
    output logic                   hit
);

    logic [BYTE_W-1:0] byte_reg;
    logic              care_reg;
    logic              match_reg;
    logic              match_next;
    logic              enable;
    logic              tail;
    logic              accepts;
    logic              update;
    logic              sel;
    logic [31:0]       len_ext;

    // Decode the active length against this cell's position
    assign len_ext = 32'(pattern_length);
    assign enable  = len_ext > 32'(CELL_INDEX);
    assign tail    = (len_ext == 32'(CELL_INDEX + 1))
                  || ((CELL_INDEX == MAX_PATTERN - 1) && enable);

    // Compare the text byte, wildcard when care is clear
    assign accepts = !care_reg || (byte_reg == data_byte);
    assign update  = enable && prev_match && accepts;

    // Drop partial match on the final byte, else advance
    assign match_next = ctrl.last ? 1'b0 : update;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.scan)
        begin
            match_reg <= match_next;
        end
    end

    // Write the pattern entry addressed by a load request
    assign sel = ctrl.load && (32'(entry_index) == 32'(CELL_INDEX));

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            byte_reg <= data_byte;
            care_reg <= must_match;
        end
    end

    assign match = match_reg;
    assign hit   = ctrl.scan && update && tail;

endmodule

`default_nettype wire

/* src/mbpc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbpc_checker
    import mbpc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire logic               item_stall,
    input  wire logic               operation,
    input  wire logic [IDX_W-1:0]   entry_index,
    input  wire logic [BYTE_W-1:0]  data_byte,
    input  wire logic               must_match,
    input  wire logic               last_byte,
    input  wire logic               result_valid,
    input  wire logic               result_stall,
    input  wire logic [COUNT_W-1:0] match_count,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [LEN_W-1:0]   cfg_data
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(match_count))
        else $error("stalled result changed");

    // Count stays within its saturation level
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> match_count != 2'd3)
        else $error("match count above saturation");

    // A new result follows only an accepted final-byte scan
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |->
            $past(item_valid && !item_stall && operation == OP_SCAN && last_byte))
        else $error("result without a final-byte scan");

    // A final-byte scan always yields a result next cycle
    a_result_given: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && operation == OP_SCAN && last_byte |=> result_valid)
        else $error("final-byte scan gave no result");

endmodule

bind masked_byte_pattern_counter_core mbpc_checker u_mbpc_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import mbpc_pkg::*;

    localparam int unsigned NPOS         = MAX_PATTERN_DEF;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned IDLE_LIMIT   = 4000;

    typedef struct packed {
        op_t               operation;
        logic [IDX_W-1:0]  entry_index;
        logic [BYTE_W-1:0] data_byte;
        logic              must_match;
        logic              last_byte;
    } request_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic               operation = 1'b0;
    logic [IDX_W-1:0]   entry_index = '0;
    logic [BYTE_W-1:0]  data_byte = '0;
    logic               must_match = 1'b0;
    logic               last_byte = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [COUNT_W-1:0] match_count;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LEN_W-1:0]   cfg_data = '0;

    masked_byte_pattern_counter_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .entry_index  (entry_index),
        .data_byte    (data_byte),
        .must_match   (must_match),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .match_count  (match_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Scanner copy: pattern, care bits, prefix-match bits, saturating count, length
    logic [BYTE_W-1:0]  pat_byte [NPOS];
    logic               pat_care [NPOS];
    logic [NPOS-1:0]    prefix_hits = '0;
    logic [COUNT_W-1:0] hit_count = '0;
    logic [LEN_W-1:0]   cur_length = '0;
    logic [COUNT_W-1:0] count_q [$];

    // Request stream and its generator-side view of the pattern
    request_t           pending_q [$];
    logic [BYTE_W-1:0]  gen_pat [NPOS];
    logic               gen_care [NPOS];
    bit                 gen_written [NPOS];
    logic [BYTE_W-1:0]  alphabet [3];
    int unsigned        pushed = 0;

    // Handshake bookkeeping
    bit                 item_taken = 1'b0;
    bit                 progress;
    bit                 quiet = 1'b0;
    int unsigned        send_gap = 0;
    int unsigned        stall_left = 0;
    int unsigned        hold_left = 0;
    int unsigned        hold_requests = 0;
    int unsigned        hold_served = 0;
    int unsigned        idle_cycles = 0;
    int unsigned        cfg_writes = 0;
    int unsigned        items_accepted = 0;
    int unsigned        results_checked = 0;
    int unsigned        errors = 0;
    logic [COUNT_W-1:0] expected_count;
    request_t           seen;
    request_t           nxt;

    // Advance the scanner by one accepted request
    task automatic apply_request(input request_t r);
        int  span;
        logic prev;
        if (r.operation == OP_LOAD)
        begin
            pat_byte[r.entry_index] = r.data_byte;
            pat_care[r.entry_index] = r.must_match;
        end
        else
        begin
            span = (cur_length > NPOS) ? NPOS : int'(cur_length);
            for (int j = span; j < NPOS; j++)
                prefix_hits[j] = 1'b0;
            // top down, so each position sees the previous byte's bits
            for (int j = span - 1; j >= 0; j--)
            begin
                prev = (j == 0) ? 1'b1 : prefix_hits[j-1];
                prefix_hits[j] = prev && (!pat_care[j] || pat_byte[j] == r.data_byte);
            end
            if (span > 0 && prefix_hits[span-1] && hit_count < COUNT_SAT)
                hit_count = hit_count + 1'b1;
            if (r.last_byte)
            begin
                count_q = {count_q, hit_count};
                prefix_hits = '0;
                hit_count = '0;
            end
        end
    endtask

    // Check results, predict accepted requests, track config writes, watch for hangs
    always @(posedge clk)
    begin
        progress = 1'b0;
        item_taken = item_valid && !item_stall;
        if (rst_n && result_valid && !result_stall)
        begin
            progress = 1'b1;
            results_checked++;
            if (count_q.size() == 0)
            begin
                $display("%0t: result with none pending: expected none, actual match_count=%0d",
                         $time, match_count);
                errors++;
            end
            else
            begin
                expected_count = count_q.pop_front();
                if (match_count !== expected_count)
                begin
                    $display("%0t: match_count expected %0d, actual %0d",
                             $time, expected_count, match_count);
                    errors++;
                end
            end
        end
        if (rst_n && item_taken)
        begin
            progress = 1'b1;
            seen.operation   = op_t'(operation);
            seen.entry_index = entry_index;
            seen.data_byte   = data_byte;
            seen.must_match  = must_match;
            seen.last_byte   = last_byte;
            apply_request(seen);
            items_accepted++;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            progress = 1'b1;
            cur_length = cfg_data;
            cfg_writes++;
        end
        if (progress || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, count_q.size());
            $display("masked_byte_pattern_counter_core: mismatch");
            $finish;
        end
    end

    // Drive requests from the pending queue, with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_q.size() > 0)
            begin
                nxt = pending_q.pop_front();
                item_valid  <= 1'b1;
                operation   <= nxt.operation;
                entry_index <= nxt.entry_index;
                data_byte   <= nxt.data_byte;
                must_match  <= nxt.must_match;
                last_byte   <= nxt.last_byte;
                if (!quiet && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 8);
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Stall the result side: random bursts, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(0, 7);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    function automatic logic [BYTE_W-1:0] noise_byte();
        if ($urandom_range(0, 4) == 0)
            return BYTE_W'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, 2)];
    endfunction

    task automatic push_load(input int idx, input logic [BYTE_W-1:0] b, input logic care);
        request_t r;
        r.operation   = OP_LOAD;
        r.entry_index = idx[IDX_W-1:0];
        r.data_byte   = b;
        r.must_match  = care;
        r.last_byte   = 1'($urandom_range(0, 1));
        pending_q = {pending_q, r};
        gen_pat[idx] = b;
        gen_care[idx] = care;
        gen_written[idx] = 1'b1;
        pushed++;
    endtask

    task automatic push_scan(input logic [BYTE_W-1:0] b, input logic last);
        request_t r;
        r.operation   = OP_SCAN;
        r.entry_index = IDX_W'($urandom_range(0, NPOS - 1));
        r.data_byte   = b;
        r.must_match  = 1'($urandom_range(0, 1));
        r.last_byte   = last;
        pending_q = {pending_q, r};
        pushed++;
    endtask

    // One text: pattern copies, noise bytes and stray loads, optionally closed
    task automatic push_text(input int span, input int budget, input bit close);
        int n;
        int pick;
        n = 0;
        while (n < budget)
        begin
            pick = $urandom_range(0, 9);
            if (span > 0 && pick < 3)
            begin
                for (int j = 0; j < span; j++)
                    push_scan(gen_care[j] ? gen_pat[j] : noise_byte(), 1'b0);
                n += span;
            end
            else if (pick == 3)
            begin
                push_load($urandom_range(0, NPOS - 1), noise_byte(),
                          1'($urandom_range(0, 1)));
            end
            else
            begin
                push_scan(noise_byte(), 1'b0);
                n++;
            end
        end
        if (close)
            push_scan(noise_byte(), 1'b1);
    endtask

    // Wait until the block is idle with nothing outstanding
    task automatic drain();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_q.size() != 0 || item_valid || count_q.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_length(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= value[LEN_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int len_value, input bit long_hold);
        int span;
        int texts;
        int budget;
        span = (len_value > NPOS) ? NPOS : len_value;
        drain();
        write_length(len_value);
        if (long_hold)
            hold_requests++;
        for (int k = 0; k < 3; k++)
            alphabet[k] = BYTE_W'($urandom_range(0, 255));
        // never scan against an unwritten entry
        for (int i = 0; i < span; i++)
            if (!gen_written[i])
                push_load(i, noise_byte(), 1'($urandom_range(0, 1)));
        if (span > 0 && span <= 12)
            for (int i = 0; i < span; i++)
                push_load(i, alphabet[$urandom_range(0, 2)], $urandom_range(0, 3) != 0);
        texts = (span > 12) ? 2 : $urandom_range(3, 8);
        for (int t = 0; t < texts; t++)
        begin
            budget = (span > 12) ? $urandom_range(span, span + 20) : $urandom_range(1, 30);
            push_text(span, budget, (t < texts - 1) || ($urandom_range(0, 2) != 0));
        end
    endtask

    int preset [8] = '{1, 5, 128, 0, 4, 255, 2, 8};
    int phase;
    int len_value;
    int unsigned random_start;

    initial
    begin
        for (int i = 0; i < NPOS; i++)
        begin
            pat_byte[i] = '0;
            pat_care[i] = 1'b0;
            gen_pat[i] = '0;
            gen_care[i] = 1'b0;
            gen_written[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero length after reset: nothing can match
        push_scan(8'h00, 1'b0);
        push_scan(8'hFF, 1'b1);
        // pattern A ? C, plus the top entry
        push_load(0, 8'h41, 1'b1);
        push_load(1, 8'h00, 1'b0);
        push_load(2, 8'h43, 1'b1);
        push_load(NPOS - 1, 8'hFF, 1'b1);
        drain();
        write_length(3);
        // single match through the wildcard
        push_scan(8'h41, 1'b0);
        push_scan(8'h7E, 1'b0);
        push_scan(8'h43, 1'b1);
        // text shorter than the pattern
        push_scan(8'h41, 1'b0);
        push_scan(8'h43, 1'b1);
        // three matches saturate at two
        push_scan(8'h41, 1'b0);
        push_scan(8'h00, 1'b0);
        push_scan(8'h43, 1'b0);
        push_scan(8'h41, 1'b0);
        push_scan(8'h80, 1'b0);
        push_scan(8'h43, 1'b0);
        push_scan(8'h41, 1'b0);
        push_scan(8'hFF, 1'b0);
        push_scan(8'h43, 1'b1);
        // load in the middle of a text, leave the text open
        push_scan(8'h41, 1'b0);
        push_load(1, 8'h20, 1'b1);
        push_scan(8'h20, 1'b0);
        push_scan(8'h43, 1'b0);
        // shorten the pattern while the text is still open
        drain();
        write_length(2);
        push_scan(8'h41, 1'b0);
        push_scan(8'h20, 1'b1);

        random_start = pushed;
        phase = 0;
        while (pushed < random_start + RANDOM_ITEMS)
        begin
            if (phase < 8)
                len_value = preset[phase];
            else if ($urandom_range(0, 9) == 0)
                len_value = $urandom_range(0, 255);
            else
                len_value = $urandom_range(1, 8);
            if (pushed >= random_start + (RANDOM_ITEMS * 85) / 100)
                quiet = 1'b1;
            run_phase(len_value, phase == 4);
            phase++;
        end

        drain();
        repeat (10) @(negedge clk);
        if (count_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, count_q.size());
            errors++;
        end
        $display("Ran %0d requests and checked %0d counts over %0d length settings,",
                 items_accepted, results_checked, cfg_writes);
        $display("including one %0d-cycle result hold-off that backed up the input.",
                 LONG_HOLD);
        if (errors == 0)
            $display("masked_byte_pattern_counter_core: match");
        else
            $display("masked_byte_pattern_counter_core: mismatch");
        $finish;
    end

endmodule
